### src/gda_pkg.sv
package gda_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned REM_W   = 9;

	localparam int unsigned YEAR_MOD  = 400;
	localparam int unsigned CENTURY   = 100;
	localparam int unsigned MONTHS    = 12;
	localparam int unsigned DAYS_LONG = 31;
	localparam int unsigned DAYS_SHORT = 30;
	localparam int unsigned DAYS_FEB_LEAP = 29;
	localparam int unsigned DAYS_FEB = 28;

	typedef enum logic {
		OP_ADD_DAYS   = 1'b0,
		OP_ADD_MONTHS = 1'b1
	} op_t;

	// leap test from the year residue mod 400
	function automatic logic is_leap(input logic [REM_W-1:0] rem);
		logic cent;
		cent = (rem == REM_W'(CENTURY)) || (rem == REM_W'(2 * CENTURY)) ||
			(rem == REM_W'(3 * CENTURY));
		return (rem == '0) || ((rem[1:0] == 2'b00) && !cent);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(DAYS_LONG);
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(DAYS_SHORT);
			4'd2: len = leap ? DAY_W'(DAYS_FEB_LEAP) : DAY_W'(DAYS_FEB);
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

### src/gda_req_if.sv
interface gda_req_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [gda_pkg::COUNT_W-1:0]   count;
	logic [gda_pkg::DAY_W-1:0]     start_day;
	logic [gda_pkg::MONTH_W-1:0]   start_month;
	logic [gda_pkg::YEAR_W-1:0]    start_year;

	modport source (output valid, op, count, start_day, start_month, start_year,
		input ready);
	modport sink (input valid, op, count, start_day, start_month, start_year,
		output ready);
endinterface

### src/gda_rsp_if.sv
interface gda_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gda_pkg::DAY_W-1:0]     end_day;
	logic [gda_pkg::MONTH_W-1:0]   end_month;
	logic [gda_pkg::YEAR_W-1:0]    end_year;
	logic                          bad_date;
	logic                          year_overflow;

	modport source (output valid, end_day, end_month, end_year, bad_date, year_overflow,
		input ready);
	modport sink (input valid, end_day, end_month, end_year, bad_date, year_overflow,
		output ready);
endinterface

### src/gda_mod400.sv
// year mod 400: the year over 16 by a shift, that quotient over 25
// by a reciprocal multiply, then the remainder by 25 set back above the low nibble
module gda_mod400 #(
	parameter int unsigned YEAR_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [YEAR_BITS-1:0]          year,
	output logic                          done,
	output logic [gda_pkg::REM_W-1:0]     rem
);

	// years up to 32 bits give x = year >> 4 below 2^28, where
	// floor(x * ceil(2^33 / 25) / 2^33) equals floor(x / 25)
	localparam int unsigned RECIP_SHIFT = 33;
	localparam logic [28:0] RECIP_25    = 29'd343597384;

	logic                        busy_q;
	logic                        done_q;
	logic [27:0]                 x_s1;
	logic [3:0]                  nib_s1;
	logic [23:0]                 quot_s1;
	logic [gda_pkg::REM_W-1:0]   rem_q;
	logic [31:0]                 year_ext;
	logic [27:0]                 x;
	logic [56:0]                 prod;
	logic [27:0]                 back;
	logic [27:0]                 rem25;

	always_comb begin
		year_ext = 32'(year);
		x        = year_ext[31:4];
		prod     = 57'(x) * 57'(RECIP_25);
		// quotient times 25 as shifts and adds
		back     = 28'({quot_s1, 4'b0000}) + 28'({quot_s1, 3'b000}) + 28'(quot_s1);
		rem25    = x_s1 - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
			if (start) begin
				x_s1    <= x;
				nib_s1  <= year_ext[3:0];
				quot_s1 <= prod[RECIP_SHIFT +: 24];
			end
			if (busy_q) begin
				rem_q <= {rem25[4:0], nib_s1};
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

### src/gregorian_date_adder.sv
// Gregorian date adder: takes a start date, an op (add days or add months)
// and a count, and returns one result word with the end date. One word is
// worked at a time; req.ready is high only while the sequencer is idle.
// A word goes from acceptance to the result register in order: the
// mod-400 unit seeds the leap-year residue (a reciprocal multiply
// registered at acceptance, then a subtract), the sequencer takes the
// residue and checks the start date, makes each day or month step in the
// shared month/year advance unit, and loads the result register when it is
// empty or being drained on rsp.ready. A bad start date
// or a zero count skips the steps. The result register lets a finished word
// wait on rsp.ready while the next request is taken. Months added clamp the
// day to each new month, so an earlier clamp carries into later steps. The
// year wraps to 0 past 2^YEAR_BITS - 1 and sets year_overflow; only the low
// COUNT_BITS of count and the low YEAR_BITS of start_year are used.
module gregorian_date_adder #(
	parameter int unsigned COUNT_BITS = 16,
	parameter int unsigned YEAR_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gda_req_if.sink   req,
	gda_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic                            op_q;
	logic [COUNT_BITS-1:0]           n_q;
	logic [gda_pkg::DAY_W-1:0]       d_q;
	logic [gda_pkg::MONTH_W-1:0]     m_q;
	logic [YEAR_BITS-1:0]            y_q;
	logic [gda_pkg::REM_W-1:0]       rem_q;
	logic                            bad_q;
	logic                            wrap_q;

	// result register
	logic                            out_valid_q;
	logic [gda_pkg::DAY_W-1:0]       out_day_q;
	logic [gda_pkg::MONTH_W-1:0]     out_month_q;
	logic [gda_pkg::YEAR_W-1:0]      out_year_q;
	logic                            out_bad_q;
	logic                            out_wrap_q;

	logic                            accept;
	logic [31:0]                     count_ext;
	logic [31:0]                     year_ext;
	logic [31:0]                     y_out_ext;
	logic                            mod_done;
	logic [gda_pkg::REM_W-1:0]       mod_rem;

	// shared step unit signals
	logic [gda_pkg::DAY_W-1:0]       len_cur;
	logic                            bad_start;
	logic                            adv;
	logic                            roll_year;
	logic                            y_wrap;
	logic [gda_pkg::MONTH_W-1:0]     m_nxt;
	logic [YEAR_BITS-1:0]            y_nxt;
	logic [gda_pkg::REM_W-1:0]       rem_nxt;
	logic [gda_pkg::DAY_W-1:0]       len_nxt;
	logic [gda_pkg::DAY_W-1:0]       d_nxt;
	logic                            slot_free;
	logic                            load_out;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign count_ext = 32'(req.count);
	assign year_ext  = 32'(req.start_year);
	assign y_out_ext = 32'(y_q);
	assign slot_free = !out_valid_q || rsp.ready;
	assign load_out  = (state_q == ST_DONE) && slot_free;

	gda_mod400 #(
		.YEAR_BITS(YEAR_BITS)
	) u_mod400 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.year   (year_ext[YEAR_BITS-1:0]),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_comb begin
		len_cur   = gda_pkg::month_len(m_q, gda_pkg::is_leap(rem_q));
		bad_start = (m_q < gda_pkg::MONTH_W'(1)) ||
			(m_q > gda_pkg::MONTH_W'(gda_pkg::MONTHS)) ||
			(d_q == '0) || (d_q > len_cur);

		// a month step always advances; a day step only at month end
		adv       = (op_q == gda_pkg::OP_ADD_MONTHS) || (d_q >= len_cur);
		roll_year = adv && (m_q >= gda_pkg::MONTH_W'(gda_pkg::MONTHS));
		y_wrap    = roll_year && (y_q == '1);

		if (!adv) begin
			m_nxt = m_q;
		end else if (roll_year) begin
			m_nxt = gda_pkg::MONTH_W'(1);
		end else begin
			m_nxt = m_q + gda_pkg::MONTH_W'(1);
		end

		// the 400-year residue follows the year, so no divider on the step path
		if (!roll_year) begin
			y_nxt   = y_q;
			rem_nxt = rem_q;
		end else if (y_wrap) begin
			y_nxt   = '0;
			rem_nxt = '0;
		end else begin
			y_nxt = y_q + YEAR_BITS'(1);
			if (rem_q == gda_pkg::REM_W'(gda_pkg::YEAR_MOD - 1)) begin
				rem_nxt = '0;
			end else begin
				rem_nxt = rem_q + gda_pkg::REM_W'(1);
			end
		end

		len_nxt = gda_pkg::month_len(m_nxt, gda_pkg::is_leap(rem_nxt));

		if (op_q == gda_pkg::OP_ADD_DAYS) begin
			d_nxt = adv ? gda_pkg::DAY_W'(1) : d_q + gda_pkg::DAY_W'(1);
		end else begin
			// clamp to the new month
			d_nxt = (d_q > len_nxt) ? len_nxt : d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may replace one drained in the same cycle
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q    <= req.op;
						n_q     <= count_ext[COUNT_BITS-1:0];
						d_q     <= req.start_day;
						m_q     <= req.start_month;
						y_q     <= year_ext[YEAR_BITS-1:0];
						wrap_q  <= 1'b0;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						rem_q   <= mod_rem;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					bad_q <= bad_start;
					if (bad_start || (n_q == '0)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					d_q   <= d_nxt;
					m_q   <= m_nxt;
					y_q   <= y_nxt;
					rem_q <= rem_nxt;
					n_q   <= n_q - COUNT_BITS'(1);
					if (y_wrap) begin
						wrap_q <= 1'b1;
					end
					if (n_q == COUNT_BITS'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						out_day_q   <= d_q;
						out_month_q <= m_q;
						out_year_q  <= y_out_ext[gda_pkg::YEAR_W-1:0];
						out_bad_q   <= bad_q;
						out_wrap_q  <= wrap_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.end_day       = out_day_q;
	assign rsp.end_month     = out_month_q;
	assign rsp.end_year      = out_year_q;
	assign rsp.bad_date      = out_bad_q;
	assign rsp.year_overflow = out_wrap_q;

	// no step runs with a zero count or from an invalid date
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (n_q != '0))
		else $error("step with zero count");

	a_step_date: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> ((m_q >= gda_pkg::MONTH_W'(1)) &&
		(m_q <= gda_pkg::MONTH_W'(gda_pkg::MONTHS)) && (d_q != '0) && (d_q <= len_cur)))
		else $error("invalid date while stepping");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CHECK) || (state_q == ST_STEP)) |->
		(rem_q < gda_pkg::REM_W'(gda_pkg::YEAR_MOD)))
		else $error("year residue out of range");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STEP) && (n_q == COUNT_BITS'(1))) |=> (state_q == ST_DONE))
		else $error("missed end of stepping");

endmodule
